[sv/bchr_pkg.sv]
// shared types and constants for the button click, hold and release detector
package bchr_pkg;

   localparam int TIMER_WIDTH_DEFAULT = 16;
   localparam int CFG_WIDTH           = 16;
   localparam int CSR_ADDR_WIDTH      = 4;
   localparam int CSR_DATA_WIDTH      = 32;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET      = 16'd50;
   localparam logic [CFG_WIDTH-1:0] HOLD_RESET          = 16'd500;
   localparam logic [CFG_WIDTH-1:0] RELEASE_CLEAR_TICKS = 16'd100;

   typedef enum logic [1:0] {
      REG_DEBOUNCE = 2'd0,
      REG_HOLD     = 2'd1,
      REG_ENABLE   = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_ms;
      logic [CFG_WIDTH-1:0] hold_ms;
      logic                 enable;
   } cfg_type;

endpackage

[sv/bchr_csr.sv]
// configuration register file behind the apb-style port
module bchr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bchr_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [bchr_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [bchr_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready,
   output bchr_pkg::cfg_type                    cfg
);
   import bchr_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_DEBOUNCE: cfg_in.debounce_ms = csr_pwdata[CFG_WIDTH-1:0];
            REG_HOLD:     cfg_in.hold_ms     = csr_pwdata[CFG_WIDTH-1:0];
            REG_ENABLE:   cfg_in.enable      = csr_pwdata[0];
            default:      cfg_in             = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_DEBOUNCE: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.debounce_ms);
         REG_HOLD:     csr_prdata = CSR_DATA_WIDTH'(cfg_ff.hold_ms);
         REG_ENABLE:   csr_prdata = CSR_DATA_WIDTH'(cfg_ff.enable);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms <= DEBOUNCE_RESET;
         cfg_ff.hold_ms     <= HOLD_RESET;
         cfg_ff.enable      <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[sv/bchr_core.sv]
// input register, per-tick detector update and result register
module bchr_core #(
   parameter int TIMER_WIDTH = bchr_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  bchr_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_button_level,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_click_event,
   output logic              rsp_hold_event,
   output logic              rsp_release_event,
   output logic              rsp_level_now
);
   import bchr_pkg::*;

   localparam int CMP_WIDTH = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

   // input stage
   logic in_valid_ff, in_valid_in;
   logic in_level_ff, in_level_in;

   // result stage
   logic out_valid_ff, out_valid_in;
   logic click_ev_ff, click_ev_in;
   logic hold_ev_ff, hold_ev_in;
   logic release_ev_ff, release_ev_in;
   logic level_now_ff, level_now_in;

   // detector state
   logic                   raw_ff, raw_in;
   logic                   latched_ff, latched_in;
   logic [TIMER_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic                   click_lvl_ff, click_lvl_in;
   logic                   hold_lvl_ff, hold_lvl_in;
   logic                   release_lvl_ff, release_lvl_in;
   logic                   click_arm_ff, click_arm_in;
   logic                   hold_arm_ff, hold_arm_in;
   logic                   release_arm_ff, release_arm_in;

   logic                   out_free;
   logic                   advance;
   logic                   lvl;
   logic [TIMER_WIDTH-1:0] tick_count;
   logic [TIMER_WIDTH-1:0] start_count;
   logic                   start_latched;
   logic                   past_debounce;
   logic                   past_hold;
   logic                   release_hit;
   logic [TIMER_WIDTH-1:0] end_count;
   logic                   past_clear;
   logic                   click_lvl_new, hold_lvl_new, release_lvl_new;
   logic                   click_arm_new, hold_arm_new, release_arm_new;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign lvl       = in_level_ff;

   assign tick_count    = (elapsed_ff == TIMER_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
   assign start_latched = latched_ff || lvl;
   assign start_count   = (lvl && !latched_ff) ? '0 : tick_count;
   assign past_debounce = CMP_WIDTH'(start_count) > CMP_WIDTH'(cfg.debounce_ms);
   assign past_hold     = CMP_WIDTH'(start_count) > CMP_WIDTH'(cfg.hold_ms);
   assign release_hit   = !lvl && start_latched && past_debounce;
   assign end_count     = release_hit ? '0 : start_count;
   assign past_clear    = CMP_WIDTH'(end_count) > CMP_WIDTH'(RELEASE_CLEAR_TICKS);

   always_comb begin
      raw_in         = raw_ff;
      latched_in     = latched_ff;
      elapsed_in     = elapsed_ff;
      click_lvl_new  = click_lvl_ff;
      hold_lvl_new   = hold_lvl_ff;
      release_lvl_new = release_lvl_ff;
      click_arm_new  = click_arm_ff;
      hold_arm_new   = hold_arm_ff;
      release_arm_new = release_arm_ff;

      if (cfg.enable) begin
         raw_in     = lvl;
         latched_in = start_latched;
         elapsed_in = end_count;
         if (past_debounce) begin
            click_lvl_new = lvl;
         end
         if (past_hold) begin
            hold_lvl_new = lvl;
         end
         if (release_hit) begin
            latched_in      = 1'b0;
            release_lvl_new = 1'b1;
            click_lvl_new   = 1'b0;
            hold_lvl_new    = 1'b0;
            click_arm_new   = 1'b1;
            hold_arm_new    = 1'b1;
            release_arm_new = 1'b1;
         end else if (!lvl && !start_latched && past_clear) begin
            release_lvl_new = 1'b0;
         end
      end else begin
         elapsed_in = tick_count;
      end

      // one-shot reporting
      click_ev_in    = click_lvl_new && click_arm_new;
      hold_ev_in     = hold_lvl_new && hold_arm_new;
      release_ev_in  = release_lvl_new && release_arm_new;
      click_arm_in   = click_arm_new && !click_ev_in;
      hold_arm_in    = hold_arm_new && !hold_ev_in;
      release_arm_in = release_arm_new && !release_ev_in;
      click_lvl_in   = click_lvl_new;
      hold_lvl_in    = hold_lvl_new;
      release_lvl_in = release_lvl_new;
      level_now_in   = raw_in;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_level_in = in_level_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_level_in = req_button_level;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         raw_ff         <= 1'b0;
         latched_ff     <= 1'b0;
         elapsed_ff     <= '0;
         click_lvl_ff   <= 1'b0;
         hold_lvl_ff    <= 1'b0;
         release_lvl_ff <= 1'b0;
         click_arm_ff   <= 1'b1;
         hold_arm_ff    <= 1'b1;
         release_arm_ff <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            raw_ff         <= raw_in;
            latched_ff     <= latched_in;
            elapsed_ff     <= elapsed_in;
            click_lvl_ff   <= click_lvl_in;
            hold_lvl_ff    <= hold_lvl_in;
            release_lvl_ff <= release_lvl_in;
            click_arm_ff   <= click_arm_in;
            hold_arm_ff    <= hold_arm_in;
            release_arm_ff <= release_arm_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_level_ff <= in_level_in;
      if (advance) begin
         click_ev_ff   <= click_ev_in;
         hold_ev_ff    <= hold_ev_in;
         release_ev_ff <= release_ev_in;
         level_now_ff  <= level_now_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_click_event   = click_ev_ff;
   assign rsp_hold_event    = hold_ev_ff;
   assign rsp_release_event = release_ev_ff;
   assign rsp_level_now     = level_now_ff;

endmodule

[sv/button_click_hold_release_detector_unit.sv]
// Button click, hold and release detector. Each request transaction carries one
// millisecond tick with the sampled button level and yields exactly one response
// transaction with one-shot click, hold and release events and the stored raw
// level. One transaction is taken every cycle while req_stall is low; a tick
// passes an input register and a result register, moving into the result register
// whenever that register is free, and its response is offered from there.
// Thresholds and enable sit in registers on the apb-style port and should be
// changed only while no transaction is in flight.
module button_click_hold_release_detector_unit #(
   parameter int TIMER_WIDTH = bchr_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_button_level,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_click_event,
   output logic                                rsp_hold_event,
   output logic                                rsp_release_event,
   output logic                                rsp_level_now,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bchr_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [bchr_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [bchr_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import bchr_pkg::*;

   cfg_type cfg;

   bchr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bchr_core #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_button_level  (req_button_level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_click_event   (rsp_click_event),
      .rsp_hold_event    (rsp_hold_event),
      .rsp_release_event (rsp_release_event),
      .rsp_level_now     (rsp_level_now)
   );

   // a release report stands alone
   a_release_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_release_event |-> !rsp_click_event && !rsp_hold_event)
      else $error("release reported together with click or hold");

   // a release is only seen with the button up
   a_release_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_release_event |-> !rsp_level_now)
      else $error("release reported with button pressed");

   // click and hold only fire with the button down
   a_press_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_click_event || rsp_hold_event) |-> rsp_level_now)
      else $error("click or hold reported with button released");

   // the input side only stalls behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

endmodule
